>>> src/mfbp_pkg.sv
// ----------------------------------------------------------------------------
// MSB-first bit packer package
// Shared widths, defaults and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package mfbp_pkg;

    localparam int VALUE_W        = 64;  // input field value width
    localparam int COUNT_W        = 7;   // bit count width, 0..127
    localparam int BYTE_W         = 8;   // output byte width
    localparam int OFF_W          = 3;   // bit offset into the partial byte
    localparam int STEP_W         = 4;   // bits taken in one step, 0..8
    localparam int MAX_FIELD_BITS = 64;  // default field limit

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture a new input transaction
        logic step;   // move up to one byte worth of bits
        logic flush;  // emit the zero-padded partial byte
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic rem_zero;    // no field bits left to pack
        logic flush_due;   // finish requested and partial byte not empty
        logic emit_step;   // the next step completes a byte
        logic final_step;  // the next step ends the transaction
        logic out_free;    // output register can take a byte this cycle
    } status_t;

endpackage

>>> src/mfbp_if.sv
// ----------------------------------------------------------------------------
// MSB-first bit packer channels
// Valid/ready channels for input fields and packed output bytes.
// ----------------------------------------------------------------------------
interface mfbp_in_if;
    logic                              valid;
    logic                              ready;
    logic [mfbp_pkg::VALUE_W-1:0]      value;
    logic [mfbp_pkg::COUNT_W-1:0]      bit_count;
    logic                              finish;

    modport source (output valid, output value, output bit_count, output finish,
                    input ready);
    modport sink   (input valid, input value, input bit_count, input finish,
                    output ready);
endinterface

interface mfbp_out_if;
    logic                              valid;
    logic                              ready;
    logic [mfbp_pkg::BYTE_W-1:0]       out_byte;
    logic                              padded;
    logic                              last;

    modport source (output valid, output out_byte, output padded, output last,
                    input ready);
    modport sink   (input valid, input out_byte, input padded, input last,
                    output ready);
endinterface

>>> src/mfbp_ctrl.sv
// ----------------------------------------------------------------------------
// MSB-first bit packer controller
// Sequences load, byte steps and the final flush of one transaction.
// ----------------------------------------------------------------------------
module mfbp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mfbp_pkg::status_t status,
    output mfbp_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Issue commands and pick the next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!status.rem_zero)
                begin
                    // hold while a completed byte has nowhere to go
                    if (!status.emit_step || status.out_free)
                    begin
                        cmd.step = 1'b1;
                        if (status.final_step)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else if (status.flush_due)
                begin
                    if (status.out_free)
                    begin
                        cmd.flush  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/mfbp_dp.sv
// ----------------------------------------------------------------------------
// MSB-first bit packer datapath
// Aligned field shifter, partial byte, bit offset and output register.
// ----------------------------------------------------------------------------
module mfbp_dp #(
    parameter int MAX_BITS = mfbp_pkg::MAX_FIELD_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mfbp_pkg::cmd_t                  cmd,
    output mfbp_pkg::status_t               status,
    input  logic [mfbp_pkg::VALUE_W-1:0]    value,
    input  logic [mfbp_pkg::COUNT_W-1:0]    bit_count,
    input  logic                            finish,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mfbp_pkg::BYTE_W-1:0]     out_byte,
    output logic                            padded,
    output logic                            last
);

    localparam int REM_W  = $clog2(MAX_BITS + 1);
    localparam int BW     = mfbp_pkg::BYTE_W;
    localparam int STEP_W = mfbp_pkg::STEP_W;
    localparam int OFF_W  = mfbp_pkg::OFF_W;

    logic [MAX_BITS-1:0] val_reg;
    logic [REM_W-1:0]    rem_reg;
    logic                fin_reg;
    logic [BW-1:0]       partial_reg;
    logic [OFF_W-1:0]    off_reg;
    logic                ovalid_reg;
    logic [BW-1:0]       obyte_reg;
    logic                opad_reg;
    logic                olast_reg;

    logic [REM_W-1:0]    cnt;
    logic [STEP_W-1:0]   avail;
    logic [STEP_W-1:0]   take;
    logic [STEP_W-1:0]   off_sum;
    logic [BW-1:0]       merged;
    logic                take_all;
    logic                emit;
    logic [REM_W-1:0]    rem_left;
    logic                last_byte;

    // Saturate the count to the field limit
    assign cnt = (bit_count > mfbp_pkg::COUNT_W'(MAX_BITS)) ? REM_W'(MAX_BITS)
                                                             : REM_W'(bit_count);

    // Bits taken this step: what is left, capped by room in the byte
    assign avail    = STEP_W'(BW) - STEP_W'(off_reg);
    assign take_all = (rem_reg <= REM_W'(avail));
    assign take     = take_all ? STEP_W'(rem_reg) : avail;
    assign off_sum  = STEP_W'(off_reg) + take;
    assign emit     = (off_sum == STEP_W'(BW));
    assign merged   = partial_reg | (val_reg[MAX_BITS-1 -: BW] >> off_reg);

    // A completed byte is the last one unless a full byte or a flush still follows
    assign rem_left  = rem_reg - REM_W'(take);
    assign last_byte = (rem_left < REM_W'(BW)) && !(fin_reg && (rem_left != '0));

    // Report status
    assign status.rem_zero   = (rem_reg == '0);
    assign status.flush_due  = fin_reg && (off_reg != '0);
    assign status.emit_step  = emit;
    assign status.final_step = take_all && !(fin_reg && !emit);
    assign status.out_free   = !ovalid_reg || out_ready;

    // Field shifter and bit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            fin_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            rem_reg <= cnt;
            fin_reg <= finish;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_left;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            // left-align the field; bits above the count drop out
            val_reg <= value[MAX_BITS-1:0] << (REM_W'(MAX_BITS) - cnt);
        end
        else if (cmd.step)
        begin
            val_reg <= val_reg << take;
        end
    end

    // Partial byte and offset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            off_reg     <= '0;
        end
        else if (cmd.flush || (cmd.step && emit))
        begin
            partial_reg <= '0;
            off_reg     <= '0;
        end
        else if (cmd.step)
        begin
            partial_reg <= merged;
            off_reg     <= off_sum[OFF_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.flush || (cmd.step && emit))
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.flush)
        begin
            obyte_reg <= partial_reg;
            opad_reg  <= 1'b1;
            olast_reg <= 1'b1;
        end
        else if (cmd.step && emit)
        begin
            obyte_reg <= merged;
            opad_reg  <= 1'b0;
            olast_reg <= last_byte;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign padded    = opad_reg;
    assign last      = olast_reg;

endmodule

>>> src/msb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// MSB-first bit packer
// Appends variable-width fields to a byte stream, most significant bit first.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries value, bit_count (0..127, saturated to MAX_BITS) and finish.
//   out_ch carries out_byte (first stream bit in bit 7), padded and last.
//   Both are valid/ready channels; a transaction moves when both are high.
//   An input transaction is taken only while the packer is idle. It then
//   steps once per cycle unless a completed byte has nowhere to go, moving
//   up to the free room of the partial byte; each step that fills the byte
//   loads the output register. A field of n > 0 bits at offset k takes
//   ceil((k+n)/8) steps, followed by a flush when one is due; a zero count
//   takes no step, only the flush if one is due.
//   The last byte caused by a transaction carries last; a finish with a
//   non-empty partial byte emits it zero-padded with padded set.
//   A stalled receiver holds the output register; the packer waits before
//   any step that would complete another byte, and before a flush. Partial
//   bits stay between transactions.
//   Reset empties the partial byte, clears the offset and drops out_ch.valid.
// ----------------------------------------------------------------------------
module msb_first_bit_packer #(
    parameter int MAX_BITS = mfbp_pkg::MAX_FIELD_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    mfbp_in_if.sink     in_ch,
    mfbp_out_if.source  out_ch
);

    mfbp_pkg::cmd_t    cmd;
    mfbp_pkg::status_t status;

    // Controller
    mfbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    mfbp_dp #(
        .MAX_BITS (MAX_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (in_ch.value),
        .bit_count (in_ch.bit_count),
        .finish    (in_ch.finish),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_byte  (out_ch.out_byte),
        .padded    (out_ch.padded),
        .last      (out_ch.last)
    );

endmodule
